FILE: rtl/tbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbg_pkg: shared types and constants of the tone burst generator
// Configuration indexes, fixed field widths, controller/datapath handshake.
// ----------------------------------------------------------------------------
package tbg_pkg;

  localparam int PHASE_BITS    = 24;
  localparam int AMP_BITS      = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // Envelope angle divider: 8 restoring steps per cycle, 24 quotient bits in all
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_SAMPLE_COUNT = 2'd1,
    CFG_AMPLITUDE    = 2'd2
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // transaction accepted, apply begin request
    logic setup;       // classify index, seed divider, read sine
    logic div_step;    // one divider step (DIV_STEPS quotient bits)
    logic cap_sine;    // latch sine table data
    logic rom_cos;     // table address from envelope angle
    logic cap_env;     // latch envelope
    logic mul_en;      // shared multiplier enable
    logic mul_second;  // second product (times amplitude)
    logic finish;      // load output register, advance burst state
  } tbg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;   // output register free this cycle
  } tbg_status_t;

endpackage

FILE: rtl/tbg_stream_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbg_stream_ifs: valid/ready channels of the tone burst generator
// Request channel carries the begin bit, sample channel the PCM result.
// ----------------------------------------------------------------------------
interface tbg_req_if;
  logic valid;
  logic ready;
  logic begin_req;

  modport source (output valid, output begin_req, input ready);
  modport sink   (input valid, input begin_req, output ready);
endinterface

interface tbg_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: rtl/tone_burst_generator.sv
`timescale 1ns / 1ps
// Each request steps through SINE, DIV, COS, ENV, MUL1, MUL2 and DONE, which waits
//   for a free output register. One request is in flight at a time, paced by the
//   angle divider (8 quotient bits per cycle) and the multiplier, used twice in turn.
// The request side is ready again as soon as the result is in the output register.
// Reset (rst_ni low, asynchronous): configuration registers, burst index and phase clear to 0.
// ----------------------------------------------------------------------------
// tone_burst_generator: sine tone burst with raised-cosine envelope
// One 16-bit signed PCM sample per request transaction; last marks burst end.
// ----------------------------------------------------------------------------
module tone_burst_generator
  import tbg_pkg::*;
#(
  parameter int SAMPLE_RATE     = 22050,
  parameter int SINE_TABLE_BITS = 10,
  parameter int COUNT_BITS      = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tbg_req_if.sink                  in_i,
  tbg_sample_if.source             out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // Configuration registers; the user must write them only while idle (not enforced)
  logic [PHASE_BITS-1:0] phase_step_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [AMP_BITS-1:0]   amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      count_q      <= '0;
      amp_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PHASE_STEP:   phase_step_q <= cfg_data_i[PHASE_BITS-1:0];
        CFG_SAMPLE_COUNT: count_q      <= cfg_data_i[COUNT_BITS-1:0];
        CFG_AMPLITUDE:    amp_q        <= cfg_data_i[AMP_BITS-1:0];
        default: ;        // unknown index: write dropped
      endcase
    end
  end

  tbg_cmd_t    cmd;
  tbg_status_t st;
  logic        in_ready;

  // Controller: one request transaction in flight at a time
  tbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: burst state, sine table, divider, multiplier, output register
  tbg_datapath #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .begin_req_i    (in_i.begin_req),
    .phase_step_i   (phase_step_q),
    .sample_count_i (count_q),
    .amplitude_i    (amp_q),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .sample_o       (out_o.sample),
    .last_o         (out_o.last)
  );

  assign in_i.ready = in_ready;

  // A finished sample always lands in the output register
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid)
    else $error("finished sample not presented");

  // No second request transaction while one is in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while busy");

  // Zero burst length yields a silent sample flagged last
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish && count_q == '0) |=> (out_o.last && out_o.sample == '0))
    else $error("zero count sample wrong");

  // Output register only loads when the previous sample is gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_o.valid || out_o.ready))
    else $error("pending sample overwritten");

endmodule

FILE: rtl/tbg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbg_ctrl: sequencing state machine
// Steps one transaction through table read, divider, envelope and products.
// ----------------------------------------------------------------------------
module tbg_ctrl
  import tbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tbg_status_t st_i,
  output tbg_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SINE = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_COS  = 8'b0000_1000,
    S_ENV  = 8'b0001_0000,
    S_MUL1 = 8'b0010_0000,
    S_MUL2 = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  localparam int DCW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  state_e         state_q, state_d;
  logic [DCW-1:0] div_cnt_q, div_cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SINE;
        end
      end
      S_SINE: begin
        cmd_o.setup = 1'b1;
        div_cnt_d   = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.cap_sine = (div_cnt_q == '0);
        if (div_cnt_q == DCW'(DIV_CYCLES - 1)) begin
          state_d = S_COS;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      S_COS: begin
        cmd_o.rom_cos = 1'b1;
        state_d       = S_ENV;
      end
      S_ENV: begin
        cmd_o.cap_env = 1'b1;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_second = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (st_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

FILE: rtl/tbg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbg_datapath: burst state, sine table, angle divider, shared multiplier
// Executes controller commands and holds the output register.
// ----------------------------------------------------------------------------
module tbg_datapath
  import tbg_pkg::*;
#(
  parameter int SAMPLE_RATE     = 22050,
  parameter int SINE_TABLE_BITS = 10,
  parameter int COUNT_BITS      = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbg_cmd_t                      cmd_i,
  output tbg_status_t                   st_o,
  input  logic                          begin_req_i,
  input  logic [PHASE_BITS-1:0]         phase_step_i,
  input  logic [COUNT_BITS-1:0]         sample_count_i,
  input  logic [AMP_BITS-1:0]           amplitude_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          last_o
);

  localparam int TB       = SINE_TABLE_BITS;
  localparam int AW       = TB + 1;
  localparam int DEPTH    = (1 << TB) + 1;
  localparam int RW       = COUNT_BITS + 1;
  localparam int QW       = DIV_STEPS * DIV_CYCLES;
  localparam int ANG_BITS = PHASE_BITS - 1;
  localparam int FADE_MAX = (SAMPLE_RATE * 5) / 1000;
  localparam logic [AW-1:0]         QUARTER   = AW'(1 << TB);
  localparam logic [COUNT_BITS-1:0] FADE_LIM  = COUNT_BITS'(FADE_MAX);
  localparam logic [PHASE_BITS-1:0] QUARTER_T = PHASE_BITS'(1 << (PHASE_BITS - 2));

  // Quarter-wave sine entry in Q1.15: Taylor series to x^11 in Q30
  function automatic logic [15:0] sine_entry(input int j, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'd1686629713 * 64'(j)) >> bits;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s[15:0];
  endfunction

  // Table address and sign for a turn-fraction phase
  function automatic logic [AW:0] sine_addr(input logic [PHASE_BITS-1:0] ph);
    logic [AW-1:0] idx;
    idx = {1'b0, ph[PHASE_BITS-3 -: TB]};
    if (ph[PHASE_BITS-2]) idx = QUARTER - idx;
    return {ph[PHASE_BITS-1], idx};
  endfunction

  logic [15:0] sine_rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(g, TB);
    assign sine_rom[g] = ENTRY;
  end

  // Burst state
  logic [COUNT_BITS-1:0] idx_q, idx_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;

  // Per-transaction working registers
  logic                  blank_q, end_q, shaped_q;
  logic [COUNT_BITS-1:0] fade_q;
  logic [RW-1:0]         rem_q;
  logic [QW-1:0]         quo_q;
  logic [15:0]           rom_q;
  logic                  rom_neg_q;
  logic [15:0]           s_mag_q;
  logic                  s_neg_q;
  logic [16:0]           env_q;
  logic [47:0]           prod_q;

  // Output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          last_q;

  // Index classification
  logic [COUNT_BITS-1:0] fade_raw, fade_v, k_v;
  logic                  blank_v, end_v, shaped_v;

  always_comb begin
    fade_raw = sample_count_i >> 2;
    fade_v   = (fade_raw > FADE_LIM) ? FADE_LIM : fade_raw;
    blank_v  = (sample_count_i == '0) || (idx_q >= sample_count_i);
    end_v    = (idx_q == sample_count_i - 1'b1);
    shaped_v = (fade_v != '0) &&
               ((idx_q < fade_v) || (idx_q >= sample_count_i - fade_v));
    k_v      = (idx_q < fade_v) ? idx_q : (sample_count_i - 1'b1 - idx_q);
  end

  // Restoring division, DIV_STEPS quotient bits per cycle
  logic [RW-1:0]        rem_v;
  logic [DIV_STEPS-1:0] qbits;

  always_comb begin
    rem_v = rem_q;
    qbits = '0;
    for (int n = 0; n < DIV_STEPS; n++) begin
      rem_v = rem_v << 1;
      if (rem_v >= {1'b0, fade_q}) begin
        rem_v                  = rem_v - {1'b0, fade_q};
        qbits[DIV_STEPS-1-n]   = 1'b1;
      end
    end
  end

  // floor((k << QW) / fade) >> 1 equals floor((k << ANG_BITS) / fade)
  logic [PHASE_BITS-1:0] cos_phase;
  logic [AW:0]           rom_sel;

  assign cos_phase = {1'b0, quo_q[QW-1 -: ANG_BITS]} + QUARTER_T;
  assign rom_sel   = sine_addr(cmd_i.rom_cos ? cos_phase : phase_q);

  always_ff @(posedge clk_i) begin
    rom_q     <= sine_rom[rom_sel[AW-1:0]];
    rom_neg_q <= rom_sel[AW];
  end

  // Shared multiplier: |sin| * env, then times amplitude
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;

  assign mul_a = cmd_i.mul_second ? prod_q[31:0] : {16'b0, s_mag_q};
  assign mul_b = cmd_i.mul_second ? {1'b0, amplitude_i} : env_q;
  assign mul_p = mul_a * mul_b;

  // Times 32767, then drop 47 fraction bits
  logic [62:0]            scaled;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] res;

  assign scaled = {prod_q, 15'b0} - {15'b0, prod_q};
  assign mag    = scaled[62:47];
  assign res    = s_neg_q ? (SAMPLE_BITS'(0) - mag) : mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      blank_q  <= blank_v;
      end_q    <= end_v;
      shaped_q <= shaped_v;
      fade_q   <= fade_v;
      rem_q    <= {1'b0, k_v};
      quo_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_v;
      quo_q <= {quo_q[QW-DIV_STEPS-1:0], qbits};
    end
    if (cmd_i.cap_sine) begin
      s_mag_q <= rom_q;
      s_neg_q <= rom_neg_q;
    end
    if (cmd_i.cap_env) begin
      if (!shaped_q)      env_q <= 17'h10000;
      else if (rom_neg_q) env_q <= 17'h08000 + {1'b0, rom_q};
      else                env_q <= 17'h08000 - {1'b0, rom_q};
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p[47:0];
    end
    if (cmd_i.finish) begin
      sample_q <= blank_q ? '0 : $signed(res);
      last_q   <= blank_q | end_q;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    phase_d = phase_q;
    if (cmd_i.load && begin_req_i) begin
      idx_d   = '0;
      phase_d = '0;
    end else if (cmd_i.finish) begin
      if (blank_q || end_q) begin
        idx_d   = '0;
        phase_d = '0;
      end else begin
        idx_d   = idx_q + 1'b1;
        phase_d = phase_q + phase_step_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      phase_q <= phase_d;
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign st_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign last_o         = last_q;

endmodule

FILE: dv/tb_tone_burst_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_burst_generator: self-checking bench for the tone burst generator
// Sends begin/continue requests and checks every PCM sample and last flag
// against a fixed-point burst model kept in the bench. A short list of
// directed rows comes first, then random register settings and bursts.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_tone_burst_generator;
  import tbg_pkg::*;

  // Quarter-wave sine table geometry and envelope clamp (5 ms at 22050 Hz)
  localparam int SINE_BITS    = 10;
  localparam int QUARTER      = 1 << SINE_BITS;
  localparam int FADE_LIMIT   = (22050 * 5) / 1000;
  localparam int RANDOM_ITEMS = 725;
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 20;    // idle time after the bench has quiesced
  localparam int PLAN_ROWS    = 36;

  // Index 3 decodes to no register; writes there must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } pcm_t;

  typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_e;

  // Directed row: either a register write or one request transaction.
  // Where typed is set, the expected sample is given right here.
  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_BITS-1:0]   reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_data;
    bit                        begin_bit;
    bit                        typed;
    logic signed [SAMPLE_BITS-1:0] want_sample;
    bit                        want_last;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  tbg_req_if    req_if ();
  tbg_sample_if pcm_if ();

  tone_burst_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (pcm_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Burst model: register copies, burst position and tone phase
  // --------------------------------------------------------------------------
  int unsigned quarter_sine [0:QUARTER];
  logic [PHASE_BITS-1:0] step_reg;
  logic [11:0]           len_reg;
  logic [AMP_BITS-1:0]   amp_reg;
  logic [11:0]           burst_pos;
  logic [PHASE_BITS-1:0] tone_phase;

  pcm_t pcm_due [$];   // samples still owed by the block

  // Bench bookkeeping
  int  errors;
  int  n_sent, n_got, n_bursts, n_begins, n_writes, n_overrun, n_empty;
  int  idle_cycles;
  bit  calm;           // no stalls on either side while set
  bit  hold_typed;     // typed expectation of the request on the bus
  pcm_t hold_want;

  // Q1.15 sine table: Taylor series to x^11 in Q30, rounded half up
  initial begin : build_sine
    longint unsigned x, x2, t, s;
    int unsigned taylor_div [5];
    taylor_div = '{110, 72, 42, 20, 6};
    for (longint unsigned j = 0; j <= QUARTER; j++) begin
      x  = (64'd1686629713 * j) / QUARTER;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int d = 0; d < 5; d++) t = (64'd1 << 30) - ((x2 * t) >> 30) / taylor_div[d];
      s = (x * t) >> 30;
      s = (s + (64'd1 << 14)) >> 15;
      if (s > 32768) s = 32768;
      quarter_sine[j] = int'(s);
    end
  end

  // Sine of a turn fraction: quadrant from the top two bits, mirrored table
  function automatic int sine_q15(input logic [PHASE_BITS-1:0] ph);
    int v;
    logic [SINE_BITS-1:0] ix;
    ix = ph[21 -: SINE_BITS];
    v  = ph[22] ? int'(quarter_sine[QUARTER - ix]) : int'(quarter_sine[ix]);
    return ph[23] ? -v : v;
  endfunction

  // Forms the sample for one request and advances the burst
  function automatic pcm_t next_pcm(input bit restart);
    int unsigned     cnt, idx, fade, k, env, ang;
    int              s;
    longint unsigned mag;
    bit              shaped;
    pcm_t            r;
    if (restart) begin
      burst_pos  = '0;
      tone_phase = '0;
    end
    cnt      = 32'(len_reg);
    idx      = 32'(burst_pos);
    r.sample = '0;
    r.last   = 1'b1;
    if (cnt == 0) begin
      n_empty++;
    end else if (idx >= cnt) begin
      // count was lowered under the running position
      n_overrun++;
    end else begin
      fade = cnt / 4;
      if (fade > FADE_LIMIT) fade = FADE_LIMIT;
      env = 65536;
      if (fade > 0) begin
        shaped = 1'b1;
        k      = 0;
        if (idx < fade) k = idx;
        else if (idx >= cnt - fade) k = cnt - 1 - idx;
        else shaped = 1'b0;
        if (shaped) begin
          // raised cosine: (1 - cos(pi*k/fade)) / 2 in Q16, angle as a turn fraction
          ang = (k << 23) / fade;
          env = 32768 - sine_q15(PHASE_BITS'(ang + 32'h400000));
        end
      end
      s   = sine_q15(tone_phase);
      mag = 64'((s < 0) ? -s : s);
      mag = mag * env;
      mag = (mag * amp_reg * 64'd32767) >> 47;
      r.sample = (s < 0) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
      r.last   = (idx == cnt - 1);
    end
    if (r.last) begin
      burst_pos  = '0;
      tone_phase = '0;
    end else begin
      burst_pos  = burst_pos + 1'b1;
      tone_phase = tone_phase + step_reg;
    end
    return r;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: config writes, request transactions, sample transactions.
  // Everything is sampled at the rising edge; the bench drives on the fall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    pcm_t want;
    if (!rst_ni) begin
      step_reg   <= '0;
      len_reg    <= '0;
      amp_reg    <= '0;
      burst_pos  <= '0;
      tone_phase <= '0;
    end else begin
      if (cfg_we_i) begin
        n_writes++;
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PHASE_STEP:   step_reg = cfg_data_i[PHASE_BITS-1:0];
          CFG_SAMPLE_COUNT: len_reg  = cfg_data_i[11:0];
          CFG_AMPLITUDE:    amp_reg  = cfg_data_i[AMP_BITS-1:0];
          default: ;  // spare index, dropped
        endcase
      end
      // output first: a sample can never belong to a request of this edge
      if (pcm_if.valid && pcm_if.ready) begin
        n_got++;
        if (pcm_due.size() == 0) begin
          report($sformatf("sample %0d last %0b with nothing outstanding",
                           pcm_if.sample, pcm_if.last));
        end else begin
          want = pcm_due.pop_front();
          if (pcm_if.sample !== want.sample)
            report($sformatf("sample %0d, want %0d (transaction %0d)",
                             pcm_if.sample, want.sample, n_got));
          if (pcm_if.last !== want.last)
            report($sformatf("last %0b, want %0b (transaction %0d)",
                             pcm_if.last, want.last, n_got));
          if (want.last) n_bursts++;
        end
      end
      if (req_if.valid && req_if.ready) begin
        n_sent++;
        if (req_if.begin_req) n_begins++;
        want = next_pcm(req_if.begin_req);
        if (hold_typed) want = hold_want;
        pcm_due.insert(pcm_due.size(), want);
      end
    end
  end

  // Watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (pcm_if.valid && pcm_if.ready)
        || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles, %0d samples outstanding",
               $time, IDLE_LIMIT, pcm_due.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sample side backpressure: about 11 stalls in a hundred outside the calm stretch
  always @(negedge clk_i) begin
    pcm_if.ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task starts and ends at a falling edge.
  // --------------------------------------------------------------------------

  // One request transaction. Valid stays high into the next call unless that
  // call decides on a gap, so valid only ever gets one update per edge.
  task automatic put_req(input bit b, input bit typed, input pcm_t want);
    int target;
    target = n_sent + 1;
    while (!calm && $urandom_range(0, 99) < 11) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.begin_req <= b;
    hold_typed = typed;
    hold_want  = want;
    do @(negedge clk_i); while (n_sent != target);
  endtask

  // Drop valid and let every owed sample come out before touching registers
  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pcm_due.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Directed rows: empty burst after reset, spare index, silent burst at zero
  // amplitude, one-sample burst, quarter-turn and full-scale phase steps at
  // full amplitude, a mid-burst begin and a count lowered under the position.
  // --------------------------------------------------------------------------
  row_t plan [PLAN_ROWS];

  initial begin
    plan = '{
      // count is zero after reset: every request ends an empty burst
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b1},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b1, 1'b1, 16'sd0, 1'b1},
      '{ROW_WRITE, CFG_SPARE_IDX,    24'hFFFFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b1},
      // zero amplitude, count 4 with junk above bit 11
      '{ROW_WRITE, CFG_AMPLITUDE,    24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_WRITE, CFG_SAMPLE_COUNT, 24'hFFF004, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_WRITE, CFG_PHASE_STEP,   24'h123456, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b1},
      // one-sample burst at full amplitude: phase zero gives silence
      '{ROW_WRITE, CFG_SAMPLE_COUNT, 24'h000001, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_WRITE, CFG_AMPLITUDE,    24'h00FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b1, 1'b1, 16'sd0, 1'b1},
      // quarter-turn step hits the table ends on every sample
      '{ROW_WRITE, CFG_SAMPLE_COUNT, 24'h000008, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_WRITE, CFG_PHASE_STEP,   24'h400000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b1, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      // largest step and count, begin in the middle of the attack
      '{ROW_WRITE, CFG_PHASE_STEP,   24'hFFFFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_WRITE, CFG_SAMPLE_COUNT, 24'hABCFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b1, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0},
      // position is now 4: a count of 3 leaves it past the end
      '{ROW_WRITE, CFG_SAMPLE_COUNT, 24'h000003, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b1, 16'sd0, 1'b1},
      '{ROW_SEND,  CFG_PHASE_STEP,   24'h000000, 1'b0, 1'b0, 16'sd0, 1'b0}
    };
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int   sent_random, phase_no, n, cnt;
    bit   b;
    logic [CFG_DATA_BITS-1:0] word;
    pcm_t want;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.begin_req = 1'b0;
    pcm_if.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    errors      = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    hold_typed  = 1'b0;
    hold_want   = '0;
    {n_sent, n_got, n_bursts, n_begins, n_writes, n_overrun, n_empty} = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        quiesce();
        write_reg(plan[r].reg_idx, plan[r].reg_data);
      end else begin
        want.sample = plan[r].want_sample;
        want.last   = plan[r].want_last;
        put_req(plan[r].begin_bit, plan[r].typed, want);
      end
    end

    // Random phases: new settings at each idle point, then a run of requests.
    // Position and phase carry over, so a shorter count often lands under the
    // running position. Phase 3 is one long burst where the fade clamps.
    sent_random = 0;
    phase_no    = 0;
    while (sent_random < RANDOM_ITEMS) begin
      quiesce();
      if (phase_no == 3) cnt = $urandom_range(440, 460);
      else begin
        case ($urandom_range(0, 9))
          0:       cnt = $urandom_range(0, 3);
          1:       cnt = $urandom_range(41, 250);
          default: cnt = $urandom_range(4, 40);
        endcase
      end
      if (phase_no == 3 || $urandom_range(0, 3) != 0) begin
        word       = CFG_DATA_BITS'($urandom());
        word[11:0] = cnt[11:0];
        write_reg(CFG_SAMPLE_COUNT, word);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       word = 24'h000000;
          1:       word = 24'hFFFFFF;
          2:       word = 24'h400000;
          3:       word = CFG_DATA_BITS'($urandom_range(1, 4095));
          default: word = CFG_DATA_BITS'($urandom());
        endcase
        write_reg(CFG_PHASE_STEP, word);
      end
      if (phase_no == 3 || $urandom_range(0, 3) != 0) begin
        word = CFG_DATA_BITS'($urandom());
        if (phase_no == 3) word[15:0] = 16'($urandom_range(32768, 65535));
        else if ($urandom_range(0, 4) == 0) word[15:0] = 16'h0000;
        else if ($urandom_range(0, 3) == 0) word[15:0] = 16'hFFFF;
        write_reg(CFG_AMPLITUDE, word);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_BITS'($urandom()));

      if (phase_no == 3)  n = cnt + 2;
      else if (cnt == 0)  n = $urandom_range(2, 6);
      else                n = cnt + $urandom_range(0, cnt);
      if (phase_no != 3 && n > 240) n = 240;
      if (n > RANDOM_ITEMS - sent_random) n = RANDOM_ITEMS - sent_random;

      for (int i = 0; i < n; i++) begin
        calm = (sent_random >= 250) && (sent_random < 400);
        b    = (i == 0 && $urandom_range(0, 1) == 1) || ($urandom_range(0, 99) < 3);
        put_req(b, 1'b0, '0);
        sent_random++;
      end
      calm = 1'b0;
      phase_no++;
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d requests (%0d begins) in %0d random phases, %0d register writes;",
             n_sent, n_begins, phase_no, n_writes);
    $display("%0d samples checked, %0d bursts ended, %0d empty, %0d past count.",
             n_got, n_bursts, n_empty, n_overrun);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tbg_pkg.sv
rtl/tbg_stream_ifs.sv
rtl/tbg_ctrl.sv
rtl/tbg_datapath.sv
rtl/tone_burst_generator.sv
dv/tb_tone_burst_generator.sv
